// ===== src/tcr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcr_pkg
// Shared types and constants for the text cell row rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcr_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_CELL_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CELL_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FONT_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FONT_HEIGHT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_OFFSET_X = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_OFFSET_Y = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_UL_ROW         = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_ENABLE  = 3'd7;

  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned GLYPH_W  = 16;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned RANGE_W  = 6;
  localparam int unsigned CNT_W    = 5;   // pixel counter, as wide as cell_width

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 24;

  // effect_enable bits
  localparam int unsigned FX_UNDERLINE = 0;
  localparam int unsigned FX_BOLD      = 1;

  typedef struct packed {
    logic [4:0] cell_width;
    logic [5:0] cell_height;
    logic [4:0] font_width;
    logic [5:0] font_height;
    logic [3:0] glyph_offset_x;
    logic [4:0] glyph_offset_y;
    logic [4:0] ul_row;
    logic [1:0] effect_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cell_width:     5'd8,
    cell_height:    6'd8,
    font_width:     5'd8,
    font_height:    6'd8,
    glyph_offset_x: 4'd0,
    glyph_offset_y: 5'd0,
    ul_row:         5'd0,
    effect_enable:  2'd3
  };

  // fifo status between the queue and its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

// ===== src/tcr_front.sv =====
// ----------------------------------------------------------------------------
// tcr_front
// Accepts row items, resolves colors, line range and the lit pixel mask.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_front
  import tcr_pkg::*;
#(
  parameter int unsigned MAX_CELL_WIDTH  = 16,
  parameter int unsigned MAX_CELL_HEIGHT = 32,
  parameter int unsigned GLYPH_ROW_BITS  = 16,
  parameter int unsigned DESC_W          = 2 * COLOR_W + 1 + MAX_CELL_WIDTH
)(
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_TDATA_W-1:0] s_tdata,
  input  wire cfg_t                  cfg,
  input  wire fifo_status_t          fifo_status,
  output logic                       push,
  output logic [DESC_W-1:0]          push_data
);

  localparam int unsigned PW = MAX_CELL_WIDTH;

  logic [COLOR_W-1:0] fg_in, bg_in, fg, bg;
  logic [GLYPH_W-1:0] glyph;
  logic [ROW_W-1:0]   row;
  logic               rev, invis, uline, bold, swap, hide;
  logic [RANGE_W-1:0] ls_in, le_in, ls, le, ls_dis, ul_end;
  logic [6:0]         core_end;
  logic [5:0]         span;
  logic               core, line, smear;
  logic [GLYPH_W-1:0] lit16;
  logic [PW+GLYPH_W-1:0] lit_wide;
  logic [PW-1:0]      lit, pix_mask;

  // tdata fields, lowest bits first
  assign fg_in = s_tdata[23:0];
  assign bg_in = s_tdata[47:24];
  assign glyph = s_tdata[63:48];
  assign row   = s_tdata[68:64];
  assign rev   = s_tdata[69];
  assign invis = s_tdata[70];
  assign uline = s_tdata[71];
  assign bold  = s_tdata[72];
  assign swap  = s_tdata[73];
  assign hide  = s_tdata[74];
  assign ls_in = s_tdata[80:75];
  assign le_in = s_tdata[86:81];

  always_comb begin
    // colors: swap first, then hiding copies background into foreground
    if (rev ^ swap) begin
      fg = bg_in;
      bg = fg_in;
    end else begin
      fg = fg_in;
      bg = bg_in;
    end
    if (invis || hide) begin
      fg = bg;
    end

    // cursor line range, an empty range starts at the clamped cell height
    if (32'(cfg.cell_height) < 32'(MAX_CELL_HEIGHT)) begin
      ls_dis = cfg.cell_height;
    end else begin
      ls_dis = RANGE_W'(MAX_CELL_HEIGHT);
    end
    if (ls_in >= le_in) begin
      ls = ls_dis;
      le = '0;
    end else begin
      ls = ls_in;
      le = le_in;
    end
    ul_end = RANGE_W'(cfg.ul_row) + RANGE_W'(1);
    if (cfg.effect_enable[FX_UNDERLINE] && (cfg.ul_row != '0) && uline) begin
      if (ls > RANGE_W'(cfg.ul_row)) begin
        ls = RANGE_W'(cfg.ul_row);
      end
      if (le < ul_end) begin
        le = ul_end;
      end
    end
    line = (RANGE_W'(row) >= ls) && (RANGE_W'(row) < le);

    core_end = 7'(cfg.glyph_offset_y) + 7'(cfg.font_height);
    core = (row >= cfg.glyph_offset_y) && (7'(row) < core_end);

    // glyph bits are used in whole bytes of the font width
    span = ((6'(cfg.font_width) + 6'd7) >> 3) << 3;
    for (int i = 0; i < GLYPH_W; i++) begin
      lit16[i] = core && (6'(i) < span) && (i < GLYPH_ROW_BITS) && glyph[i];
    end
    lit_wide = {{PW{1'b0}}, lit16};
    lit      = lit_wide[PW-1:0];

    smear    = cfg.effect_enable[FX_BOLD] && bold;
    pix_mask = smear ? (lit | (lit << 1)) : lit;
  end

  assign s_tready  = !fifo_status.full;
  // a zero-width cell produces nothing and is dropped here
  assign push      = s_tvalid && s_tready && (cfg.cell_width != '0);
  assign push_data = {pix_mask, line, bg, fg};

endmodule

`default_nettype wire

// ===== src/tcr_fifo.sv =====
// ----------------------------------------------------------------------------
// tcr_fifo
// Short queue of row descriptors between the front and the pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_fifo
  import tcr_pkg::*;
#(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 2
)(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output fifo_status_t          status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W_F = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W_F-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    if (32'(p) == DEPTH - 1) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W_F'(1);
        2'b01:   count <= count - CNT_W_F'(1);
        default: count <= count;
      endcase
    end
  end

  assign head_data    = entries[rd_ptr];
  assign status.full  = (32'(count) == DEPTH);
  assign status.empty = (count == '0);

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    status.full |-> !push)
    else $error("descriptor pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    status.empty |-> !pop)
    else $error("descriptor popped from an empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W_F'(1)))
    else $error("queue count lost a push");

endmodule

`default_nettype wire

// ===== src/tcr_back.sv =====
// ----------------------------------------------------------------------------
// tcr_back
// Pixel engine: walks one descriptor a pixel per clock, unless the output stalls, into the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcr_back
  import tcr_pkg::*;
#(
  parameter int unsigned MAX_CELL_WIDTH = 16,
  parameter int unsigned DESC_W         = 2 * COLOR_W + 1 + MAX_CELL_WIDTH
)(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cfg_t                   cfg,
  input  wire fifo_status_t           fifo_status,
  input  wire logic [DESC_W-1:0]      head_data,
  output logic                        pop,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tlast
);

  localparam int unsigned PW = MAX_CELL_WIDTH;

  logic [COLOR_W-1:0] fg, bg, color;
  logic               line, pad, lit, last, fire, head_valid;
  logic [PW-1:0]      pix_mask, mask_shift;
  logic [CNT_W-1:0]   k, k_next, x, cw, ox;

  assign fg       = head_data[23:0];
  assign bg       = head_data[47:24];
  assign line     = head_data[48];
  assign pix_mask = head_data[DESC_W-1:49];

  always_comb begin
    if (32'(cfg.cell_width) < 32'(MAX_CELL_WIDTH)) begin
      cw = cfg.cell_width;
    end else begin
      cw = CNT_W'(MAX_CELL_WIDTH);
    end
    if (CNT_W'(cfg.glyph_offset_x) < cw) begin
      ox = CNT_W'(cfg.glyph_offset_x);
    end else begin
      ox = cw;
    end
  end

  assign head_valid = !fifo_status.empty;
  assign fire       = head_valid && (!m_tvalid || m_tready);
  assign pad        = (k < ox);
  assign x          = k - ox;
  assign mask_shift = pix_mask >> x;
  assign lit        = !pad && mask_shift[0];
  assign color      = (line || lit) ? fg : bg;
  assign last       = (k + CNT_W'(1)) == cw;
  assign pop        = fire && last;
  assign k_next     = last ? '0 : k + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        k        <= k_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // pixel payload, red in the lowest byte
  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {color[7:0], color[15:8], color[23:16]};
      m_tlast <= last;
    end
  end

  a_k_in_cell: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (k < cw))
    else $error("pixel counter ran past the cell width");

  a_k_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !head_valid |-> (k == '0))
    else $error("pixel counter not at row start while idle");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    pop |=> (k == '0))
    else $error("row finished without restarting the counter");

endmodule

`default_nettype wire

// ===== src/text_cell_row_rasterizer.sv =====
// ----------------------------------------------------------------------------
// text_cell_row_rasterizer
// Expands one pixel row of a text cell into a stream of RGB pixels.
// ----------------------------------------------------------------------------
// Each input item is one pixel row of one character cell; the block answers
// with min(cell_width, MAX_CELL_WIDTH) pixels, left to right, tlast on the
// final one, and nothing for a zero cell width. The front resolves colors,
// cursor/underline line range and the lit pixel mask in the cycle an item is
// accepted and places it in a two-entry queue; the pixel engine emits one
// pixel per clock while m_tready allows, and the next row follows with no
// gap. The first pixel of a row passes the queue entry and then the output
// register after its item is accepted into an idle block. Input is taken
// whenever the queue has room, independent of output stalls. Configuration
// writes are accepted every cycle and take effect at once, so they belong
// between rows.
`default_nettype none

module text_cell_row_rasterizer
  import tcr_pkg::*;
#(
  parameter int unsigned MAX_CELL_WIDTH  = 16,
  parameter int unsigned MAX_CELL_HEIGHT = 32,
  parameter int unsigned GLYPH_ROW_BITS  = 16
)(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // fg_color[23:0], bg_color[47:24], glyph_bits[63:48], row[68:64],
  // cell_reverse[69], cell_invisible[70], cell_underline[71], cell_bold[72],
  // swap_colors[73], hide_glyph[74], line_first[80:75], line_stop[86:81]
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tlast,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned DESC_W = 2 * COLOR_W + 1 + MAX_CELL_WIDTH;

  cfg_t               cfg;
  fifo_status_t       fifo_status;
  logic               push, pop;
  logic [DESC_W-1:0]  push_data, head_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELL_WIDTH:     cfg.cell_width     <= cfg_data[4:0];
        REG_CELL_HEIGHT:    cfg.cell_height    <= cfg_data[5:0];
        REG_FONT_WIDTH:     cfg.font_width     <= cfg_data[4:0];
        REG_FONT_HEIGHT:    cfg.font_height    <= cfg_data[5:0];
        REG_GLYPH_OFFSET_X: cfg.glyph_offset_x <= cfg_data[3:0];
        REG_GLYPH_OFFSET_Y: cfg.glyph_offset_y <= cfg_data[4:0];
        REG_UL_ROW:         cfg.ul_row         <= cfg_data[4:0];
        REG_EFFECT_ENABLE:  cfg.effect_enable  <= cfg_data[1:0];
        default:            cfg <= cfg;
      endcase
    end
  end

  tcr_front #(
    .MAX_CELL_WIDTH  (MAX_CELL_WIDTH),
    .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT),
    .GLYPH_ROW_BITS  (GLYPH_ROW_BITS),
    .DESC_W          (DESC_W)
  ) u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .cfg         (cfg),
    .fifo_status (fifo_status),
    .push        (push),
    .push_data   (push_data)
  );

  tcr_fifo #(
    .WIDTH (DESC_W),
    .DEPTH (2)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .status    (fifo_status)
  );

  tcr_back #(
    .MAX_CELL_WIDTH (MAX_CELL_WIDTH),
    .DESC_W         (DESC_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .fifo_status (fifo_status),
    .head_data   (head_data),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

endmodule

`default_nettype wire
